>>> hdl/cslru_pkg.sv
package cslru_pkg;

  localparam int WAYS_DEF = 4;
  localparam int SETS_DEF = 256;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int TIME_W = 13;
  localparam int CFG_W  = 12;

  // widest set index before the modulo: up to 15 index bits
  localparam int IDX_XW = 15;

  localparam logic [1:0] CFG_OFFSET_BITS  = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS   = 2'd1;
  localparam logic [1:0] CFG_HIT_TIME     = 2'd2;
  localparam logic [1:0] CFG_MISS_LATENCY = 2'd3;

  localparam logic [3:0]  OFFSET_BITS_RST  = 4'd6;
  localparam logic [3:0]  INDEX_BITS_RST   = 4'd8;
  localparam logic [7:0]  HIT_TIME_RST     = 8'd1;
  localparam logic [11:0] MISS_LATENCY_RST = 12'd10;

  localparam logic [1:0] FILL_NONE     = 2'd0;
  localparam logic [1:0] FILL_EMPTY    = 2'd1;
  localparam logic [1:0] FILL_REPLACED = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [1:0] fill_kind;
    logic [1:0] way;
  } lookup_res_t;

endpackage

>>> hdl/cslru_ram.sv
module cslru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cslru_lookup.sv
module cslru_lookup import cslru_pkg::*; #(
  parameter int WAYS = WAYS_DEF,
  parameter int AGW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0]            valid_in,
  input  logic [WAYS-1:0][TAG_W-1:0] tags_in,
  input  logic [WAYS-1:0][AGW-1:0]   ages_in,
  input  logic [TAG_W-1:0]           tag,
  output logic [WAYS-1:0]            valid_out,
  output logic [WAYS-1:0][TAG_W-1:0] tags_out,
  output logic [WAYS-1:0][AGW-1:0]   ages_out,
  output lookup_res_t                res
);

  logic           hit_any;
  logic [AGW-1:0] hit_way;
  logic [AGW-1:0] victim;
  logic [AGW-1:0] sel;
  logic [AGW-1:0] old_age;

  // descending scans leave the lowest matching way
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    victim  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_in[w] && tags_in[w] == tag) begin
        hit_any = 1'b1;
        hit_way = AGW'(w);
      end
      if (ages_in[w] == '0) begin
        victim = AGW'(w);
      end
    end
  end

  assign sel     = hit_any ? hit_way : victim;
  assign old_age = ages_in[sel];

  always_comb begin
    valid_out = valid_in;
    tags_out  = tags_in;
    for (int w = 0; w < WAYS; w++) begin
      if (AGW'(w) == sel) begin
        ages_out[w] = AGW'(WAYS - 1);
      end else if (hit_any) begin
        ages_out[w] = (ages_in[w] > old_age) ? ages_in[w] - 1'b1 : ages_in[w];
      end else begin
        ages_out[w] = (ages_in[w] != '0) ? ages_in[w] - 1'b1 : ages_in[w];
      end
    end
    if (!hit_any) begin
      valid_out[sel] = 1'b1;
      tags_out[sel]  = tag;
    end
  end

  always_comb begin
    res.hit = hit_any;
    res.way = 2'(sel);
    if (hit_any) begin
      res.fill_kind = FILL_NONE;
    end else if (valid_in[sel]) begin
      res.fill_kind = FILL_REPLACED;
    end else begin
      res.fill_kind = FILL_EMPTY;
    end
  end

endmodule

>>> hdl/set_assoc_lru_cache_tags.sv
// flow: each item steps through accept, index, set read and update; the update state
//   loads the output register and waits there while out_valid is held without out_ready;
//   the set row memory is read and written once per item, so items run one at a time
// reset: synchronous; afterwards a clearing pass writes every set row (no item is
//   taken then, config writes are), config returns to defaults
module set_assoc_lru_cache_tags import cslru_pkg::*; #(
  parameter int WAYS = WAYS_DEF,
  parameter int SETS = SETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] address,
  input  logic              mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [1:0]        fill_kind,
  output logic [1:0]        way,
  output logic [TIME_W-1:0] access_time,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AGW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW    = WAYS + WAYS * TAG_W + WAYS * AGW;
  localparam int SHIFT = IDX_XW + $clog2(SETS);
  localparam int RECIP = ((1 << SHIFT) + SETS - 1) / SETS;
  localparam int RCW   = 17;
  localparam int PW    = IDX_XW + RCW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_IDX   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [AW-1:0] clr_cnt;

  logic [3:0]  offset_bits;
  logic [3:0]  index_bits;
  logic [7:0]  hit_time;
  logic [11:0] miss_latency;

  logic [ADDR_W-1:0] addr_q;
  logic              mode_q;
  logic [IDX_XW-1:0] x_q;
  logic [PW-1:0]     prod_q;
  logic [TAG_W-1:0]  tag_q;
  logic [AW-1:0]     set_q;

  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] idx_mask;
  logic [IDX_XW-1:0] x_d;
  logic [TAG_W-1:0]  tag_d;
  logic [IDX_XW-1:0] quot;
  logic [31:0]       diff;
  logic [31:0]       rem;
  logic [AW-1:0]     set_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [RW-1:0] ram_rdata;

  logic [WAYS-1:0]            row_valid;
  logic [WAYS-1:0][TAG_W-1:0] row_tags;
  logic [WAYS-1:0][AGW-1:0]   row_ages;
  logic [WAYS-1:0]            new_valid;
  logic [WAYS-1:0][TAG_W-1:0] new_tags;
  logic [WAYS-1:0][AGW-1:0]   new_ages;
  logic [WAYS-1:0][AGW-1:0]   init_ages;
  lookup_res_t                lk_res;

  logic slot_free;
  logic load_out;

  for (genvar w = 0; w < WAYS; w++) begin : g_init
    assign init_ages[w] = AGW'(w);
  end

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign load_out  = (state == ST_UPD) && slot_free;

  // address split
  assign shifted  = addr_q >> offset_bits;
  assign idx_mask = (32'd1 << index_bits) - 32'd1;
  assign x_d      = IDX_XW'(shifted & idx_mask);
  assign tag_d    = addr_q >> (5'(offset_bits) + 5'(index_bits));

  // set = x mod SETS through the reciprocal product
  assign quot  = IDX_XW'(prod_q >> SHIFT);
  assign diff  = 32'(x_q) - 32'(quot) * 32'(SETS);
  assign rem   = (diff >= 32'(SETS)) ? diff - 32'(SETS) : diff;
  assign set_d = AW'(rem);

  assign {row_valid, row_tags, row_ages} = ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = {new_valid, new_tags, new_ages};
    ram_re    = (state == ST_READ);
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = {{WAYS{1'b0}}, {(WAYS * TAG_W){1'b0}}, init_ages};
    end else if (load_out) begin
      ram_we = 1'b1;
    end
  end

  cslru_ram #(
    .WIDTH(RW),
    .DEPTH(SETS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(set_d),
    .rdata(ram_rdata)
  );

  cslru_lookup #(
    .WAYS(WAYS),
    .AGW (AGW)
  ) u_lookup (
    .valid_in (row_valid),
    .tags_in  (row_tags),
    .ages_in  (row_ages),
    .tag      (tag_q),
    .valid_out(new_valid),
    .tags_out (new_tags),
    .ages_out (new_ages),
    .res      (lk_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_IDX;
        end
      end
      ST_IDX:  state_next = ST_READ;
      ST_READ: state_next = ST_UPD;
      ST_UPD: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
      offset_bits  <= OFFSET_BITS_RST;
      index_bits   <= INDEX_BITS_RST;
      hit_time     <= HIT_TIME_RST;
      miss_latency <= MISS_LATENCY_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET_BITS:  offset_bits  <= cfg_data[3:0];
          CFG_INDEX_BITS:   index_bits   <= cfg_data[3:0];
          CFG_HIT_TIME:     hit_time     <= cfg_data[7:0];
          CFG_MISS_LATENCY: miss_latency <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_q <= address;
      mode_q <= mode;
    end
    if (state == ST_IDX) begin
      x_q    <= x_d;
      prod_q <= PW'(x_d) * PW'(RCW'(RECIP));
      tag_q  <= tag_d;
    end
    if (state == ST_READ) begin
      set_q <= set_d;
    end
    if (load_out) begin
      hit       <= lk_res.hit;
      fill_kind <= lk_res.fill_kind;
      way       <= lk_res.way;
      if (mode_q) begin
        access_time <= '0;
      end else begin
        access_time <= TIME_W'(hit_time)
                     + (lk_res.hit ? '0 : TIME_W'(miss_latency));
      end
    end
  end

endmodule
